FILE: sv/return_stack_with_repeat_counts_macros.svh
// Assertion macros for the return stack block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef RETURN_STACK_WITH_REPEAT_COUNTS_MACROS_SVH
`define RETURN_STACK_WITH_REPEAT_COUNTS_MACROS_SVH
`ifndef SYNTHESIS
`define RSRC_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rsrc assertion failed");
`define RSRC_ASSERT(label, prop) \
  `RSRC_ASSERT_CLK(label, clk_i, rst_ni, prop)
`else
`define RSRC_ASSERT_CLK(label, clk, rst_n, prop)
`define RSRC_ASSERT(label, prop)
`endif
`endif

FILE: sv/rsrc_pkg.sv
// Shared types and constants for the return address stack with repeat counts.
// No dependencies.
package rsrc_pkg;

  // Defaults for the top-level parameters
  localparam int EntriesDef    = 16;
  localparam int CountWidthDef = 3;
  localparam int AddrWidthDef  = 48;

  // Fixed widths of the transaction fields
  localparam int PcW      = 48;
  localparam int SizeW    = 4;
  localparam int TopW     = 4;
  localparam int CntFldW  = 3;
  localparam int OpW      = 2;

  localparam logic [63:0] ResetAddr = 64'h0000_0000_8000_0000;

  typedef enum logic [OpW-1:0] {
    OP_PREDICT = 2'd0,
    OP_RECOVER = 2'd1,
    OP_COMMIT  = 2'd2
  } op_e;

  // Per-cycle update request for one stack
  typedef struct packed {
    logic restore;
    logic pop;
    logic push;
  } rsrc_ctrl_t;

endpackage

FILE: sv/rsrc_stack.sv
// One circular return stack with per-entry repeat counts.
// Depends on rsrc_pkg and the assertion macro header.
`include "return_stack_with_repeat_counts_macros.svh"
module rsrc_stack #(
  parameter int ENTRIES     = rsrc_pkg::EntriesDef,
  parameter int COUNT_WIDTH = rsrc_pkg::CountWidthDef,
  parameter int ADDR_WIDTH  = rsrc_pkg::AddrWidthDef,
  parameter int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsrc_pkg::rsrc_ctrl_t          ctrl_i,
  input  logic [rsrc_pkg::TopW-1:0]     restore_top_i,
  input  logic [ADDR_WIDTH-1:0]         restore_addr_i,
  input  logic [COUNT_WIDTH-1:0]        restore_count_i,
  input  logic [ADDR_WIDTH-1:0]         ret_addr_i,
  output logic [IDX_W-1:0]              top_o,
  output logic [ADDR_WIDTH-1:0]         top_addr_o,
  output logic [COUNT_WIDTH-1:0]        top_count_o
);
  import rsrc_pkg::*;

  localparam logic [IDX_W-1:0]       LastIdx = IDX_W'(ENTRIES - 1);
  localparam logic [COUNT_WIDTH-1:0] CntMax  = {COUNT_WIDTH{1'b1}};
  localparam logic [ADDR_WIDTH-1:0]  RstAddr = ADDR_WIDTH'(ResetAddr);

  logic [ADDR_WIDTH-1:0]  addr_q [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_q  [ENTRIES];
  logic [ADDR_WIDTH-1:0]  addr_d [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_d  [ENTRIES];
  logic [IDX_W-1:0]       top_q, top_d;

  logic [TopW-1:0]        rtop_mod;
  logic [IDX_W-1:0]       t0, t1, t2, t_dec, t_inc;
  logic [ADDR_WIDTH-1:0]  a0, a1, a2;
  logic [COUNT_WIDTH-1:0] c0, c1, c2;
  logic                   pop_move, hit;

  // Snapshot pointer reduced modulo ENTRIES; at most eight subtractions.
  always_comb begin
    rtop_mod = restore_top_i;
    for (int k = 0; k < 8; k++) begin
      if (int'(rtop_mod) >= ENTRIES) begin
        rtop_mod = rtop_mod - TopW'(ENTRIES);
      end
    end
  end

  // Restore, then pop, then push: each stage sees the previous one's view.
  always_comb begin
    t0 = ctrl_i.restore ? IDX_W'(rtop_mod) : top_q;
    a0 = ctrl_i.restore ? restore_addr_i : addr_q[t0];
    c0 = ctrl_i.restore ? restore_count_i : cnt_q[t0];

    t_dec    = (t0 == '0) ? LastIdx : t0 - IDX_W'(1);
    pop_move = ctrl_i.pop && (c0 == '0);
    t1 = pop_move ? t_dec : t0;
    a1 = pop_move ? addr_q[t_dec] : a0;
    if (pop_move) begin
      c1 = cnt_q[t_dec];
    end else if (ctrl_i.pop) begin
      c1 = c0 - COUNT_WIDTH'(1);
    end else begin
      c1 = c0;
    end

    t_inc = (t1 == LastIdx) ? '0 : t1 + IDX_W'(1);
    hit   = (a1 == ret_addr_i) && (c1 != CntMax);
    t2 = hit ? t1 : t_inc;
    a2 = hit ? a1 : ret_addr_i;
    c2 = hit ? c1 + COUNT_WIDTH'(1) : '0;

    top_d = ctrl_i.push ? t2 : t1;
  end

  // Latest stage touching an entry wins.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (ctrl_i.push && (t2 == IDX_W'(i))) begin
        addr_d[i] = a2;
        cnt_d[i]  = c2;
      end else if (ctrl_i.pop && (t1 == IDX_W'(i))) begin
        addr_d[i] = a1;
        cnt_d[i]  = c1;
      end else if (ctrl_i.restore && (t0 == IDX_W'(i))) begin
        addr_d[i] = a0;
        cnt_d[i]  = c0;
      end else begin
        addr_d[i] = addr_q[i];
        cnt_d[i]  = cnt_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        addr_q[i] <= RstAddr;
        cnt_q[i]  <= '0;
      end
    end else begin
      top_q <= top_d;
      for (int i = 0; i < ENTRIES; i++) begin
        addr_q[i] <= addr_d[i];
        cnt_q[i]  <= cnt_d[i];
      end
    end
  end

  assign top_o       = top_q;
  assign top_addr_o  = addr_q[top_q];
  assign top_count_o = cnt_q[top_q];

  `RSRC_ASSERT(top_in_range_a, top_q <= LastIdx)
  `RSRC_ASSERT(idle_top_stable_a,
               !ctrl_i.restore && !ctrl_i.pop && !ctrl_i.push |=> $stable(top_q))
  `RSRC_ASSERT(push_moves_one_a,
               ctrl_i.push && !ctrl_i.pop && !ctrl_i.restore |=>
               (top_q == $past(top_q)) || (top_q == $past(t_inc)))

endmodule

FILE: sv/return_stack_with_repeat_counts.sv
// Return address stack with repeat counts: speculative and committed stacks.
// done_o is registered and rises in the cycle after a transaction is accepted; one transaction per cycle.
// busy_o is never raised; the receiver cannot stall, so results are never held back.
// Reset: both pointers zero, every entry address 0x80000000 with count zero.
// Depends on rsrc_pkg and rsrc_stack.
module return_stack_with_repeat_counts #(
  parameter int ENTRIES     = rsrc_pkg::EntriesDef,
  parameter int COUNT_WIDTH = rsrc_pkg::CountWidthDef,
  parameter int ADDR_WIDTH  = rsrc_pkg::AddrWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [rsrc_pkg::OpW-1:0]     op_i,
  input  logic                         taken_i,
  input  logic                         is_return_i,
  input  logic                         is_call_i,
  input  logic [rsrc_pkg::PcW-1:0]     branch_pc_i,
  input  logic [rsrc_pkg::SizeW-1:0]   branch_size_i,
  input  logic [rsrc_pkg::TopW-1:0]    restore_top_i,
  input  logic [rsrc_pkg::PcW-1:0]     restore_addr_i,
  input  logic [rsrc_pkg::CntFldW-1:0] restore_count_i,
  output logic                         done_o,
  output logic [rsrc_pkg::PcW-1:0]     return_target_o,
  output logic [rsrc_pkg::TopW-1:0]    snap_top_o,
  output logic [rsrc_pkg::PcW-1:0]     snap_addr_o,
  output logic [rsrc_pkg::CntFldW-1:0] snap_count_o
);
  import rsrc_pkg::*;

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic                   accept;
  logic                   spec_apply, cmt_apply;
  rsrc_ctrl_t             spec_ctrl, cmt_ctrl;
  logic [ADDR_WIDTH-1:0]  ret_addr;
  logic [IdxW-1:0]        spec_top, cmt_top;
  logic [ADDR_WIDTH-1:0]  spec_addr, cmt_addr;
  logic [COUNT_WIDTH-1:0] spec_count, cmt_count;

  logic                   done_q;
  logic [PcW-1:0]         snap_addr_q;
  logic [TopW-1:0]        snap_top_q;
  logic [CntFldW-1:0]     snap_count_q;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign ret_addr = ADDR_WIDTH'(branch_pc_i) + ADDR_WIDTH'(branch_size_i);

  always_comb begin
    spec_ctrl.restore = 1'b0;
    spec_apply        = 1'b0;
    cmt_apply         = 1'b0;
    unique case (op_i)
      OP_PREDICT: spec_apply = accept;
      OP_RECOVER: begin
        spec_ctrl.restore = accept;
        spec_apply        = accept && taken_i;
      end
      OP_COMMIT:  cmt_apply = accept && taken_i;
      default:    ;
    endcase
    spec_ctrl.pop    = spec_apply && is_return_i;
    spec_ctrl.push   = spec_apply && is_call_i;
    cmt_ctrl.restore = 1'b0;
    cmt_ctrl.pop     = cmt_apply && is_return_i;
    cmt_ctrl.push    = cmt_apply && is_call_i;
  end

  rsrc_stack #(
    .ENTRIES     (ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .IDX_W       (IdxW)
  ) u_spec (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (spec_ctrl),
    .restore_top_i   (restore_top_i),
    .restore_addr_i  (ADDR_WIDTH'(restore_addr_i)),
    .restore_count_i (COUNT_WIDTH'(restore_count_i)),
    .ret_addr_i      (ret_addr),
    .top_o           (spec_top),
    .top_addr_o      (spec_addr),
    .top_count_o     (spec_count)
  );

  // Committed stack never restores; its top is kept only for its own updates.
  rsrc_stack #(
    .ENTRIES     (ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .IDX_W       (IdxW)
  ) u_commit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (cmt_ctrl),
    .restore_top_i   ('0),
    .restore_addr_i  ('0),
    .restore_count_i ('0),
    .ret_addr_i      (ret_addr),
    .top_o           (cmt_top),
    .top_addr_o      (cmt_addr),
    .top_count_o     (cmt_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  // Snapshot is the speculative top as it stood before this transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      snap_addr_q  <= PcW'(spec_addr);
      snap_top_q   <= TopW'(spec_top);
      snap_count_q <= CntFldW'(spec_count);
    end
  end

  assign done_o          = done_q;
  assign return_target_o = snap_addr_q;
  assign snap_addr_o     = snap_addr_q;
  assign snap_top_o      = snap_top_q;
  assign snap_count_o    = snap_count_q;

endmodule
